[hw/rtl/lpg_pkg.sv]
`timescale 1ns / 1ps
// lpg_pkg: shared types and codes for the line pixel generator
// no dependencies; used by every lpg module and the top level
package lpg_pkg;

    // color field width (rgb565)
    localparam int unsigned COLOR_BITS = 16;

    // item action codes
    typedef enum logic
    {
        ACT_START   = 1'b0,
        ACT_ADVANCE = 1'b1
    } lpg_action_t;

    // direction flags of a line, worked out at line start
    typedef struct packed
    {
        logic x_is_major;
        logic step_x_negative;
        logic step_y_negative;
    } lpg_dir_t;

endpackage

[hw/rtl/line_pixel_generator_core.sv]
`timescale 1ns / 1ps
// line_pixel_generator_core: bresenham line rasterizer, one pixel item per input item
// path: an accepted item goes through the input register and then the result register
// throughput: one item per cycle unless stalled, set by the step loop on line state
// reset: rst_n clears both pipeline stages and drops any line in progress
// depends on lpg_pkg, lpg_setup, lpg_step
module line_pixel_generator_core #(
    parameter int unsigned COORD_BITS = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // input channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           action,
    input  logic [COORD_BITS-1:0]          start_x,
    input  logic [COORD_BITS-1:0]          start_y,
    input  logic [COORD_BITS-1:0]          end_x,
    input  logic [COORD_BITS-1:0]          end_y,
    input  logic [lpg_pkg::COLOR_BITS-1:0] line_color,
    // output channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           pixel_valid,
    output logic [COORD_BITS-1:0]          pixel_x,
    output logic [COORD_BITS-1:0]          pixel_y,
    output logic [lpg_pkg::COLOR_BITS-1:0] pixel_color,
    output logic                           last_pixel
);
    import lpg_pkg::*;

    localparam int unsigned CB = COORD_BITS;
    localparam logic [CB:0] LEFT_ONE = (CB+1)'(1);

    // input register stage
    logic                  s1_valid_reg;
    lpg_action_t           action_reg;
    logic [CB-1:0]         start_x_reg;
    logic [CB-1:0]         start_y_reg;
    logic [CB-1:0]         end_x_reg;
    logic [CB-1:0]         end_y_reg;
    logic [COLOR_BITS-1:0] color_reg;

    // line state
    logic [CB-1:0]         cursor_x_reg,    cursor_x_next;
    logic [CB-1:0]         cursor_y_reg,    cursor_y_next;
    logic signed [CB+2:0]  decision_reg,    decision_next;
    logic [CB-1:0]         major_reg,       major_next;
    logic [CB-1:0]         minor_reg,       minor_next;
    lpg_dir_t              dir_reg,         dir_next;
    logic [CB:0]           left_reg,        left_next;
    logic [COLOR_BITS-1:0] held_color_reg,  held_color_next;
    logic                  active_reg,      active_next;

    // result register
    logic                  out_valid_reg;
    logic                  pixel_valid_reg, pixel_valid_next;
    logic [CB-1:0]         pixel_x_reg,     pixel_x_next;
    logic [CB-1:0]         pixel_y_reg,     pixel_y_next;
    logic [COLOR_BITS-1:0] pixel_color_reg, pixel_color_next;
    logic                  last_pixel_reg,  last_pixel_next;

    // setup and step results
    logic [CB-1:0]         setup_major;
    logic [CB-1:0]         setup_minor;
    lpg_dir_t              setup_dir;
    logic signed [CB+2:0]  setup_decision;
    logic [CB-1:0]         step_x;
    logic [CB-1:0]         step_y;
    logic signed [CB+2:0]  step_decision;

    // state as seen by the current item (fresh line on start)
    logic [CB-1:0]         eff_x;
    logic [CB-1:0]         eff_y;
    logic signed [CB+2:0]  eff_decision;
    logic [CB-1:0]         eff_major;
    logic [CB-1:0]         eff_minor;
    lpg_dir_t              eff_dir;
    logic [CB:0]           eff_left;
    logic [COLOR_BITS-1:0] eff_color;
    logic                  eff_active;
    logic [CB:0]           left_dec;

    logic                  out_free;
    logic                  fire;

    // handshake
    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;

    lpg_setup #(
        .COORD_BITS (CB)
    ) u_setup (
        .start_x       (start_x_reg),
        .start_y       (start_y_reg),
        .end_x         (end_x_reg),
        .end_y         (end_y_reg),
        .delta_major   (setup_major),
        .delta_minor   (setup_minor),
        .dir           (setup_dir),
        .decision_init (setup_decision)
    );

    // pick stored or fresh line state
    always_comb
    begin
        if (action_reg == ACT_START)
        begin
            eff_x        = start_x_reg;
            eff_y        = start_y_reg;
            eff_decision = setup_decision;
            eff_major    = setup_major;
            eff_minor    = setup_minor;
            eff_dir      = setup_dir;
            eff_left     = {1'b0, setup_major} + LEFT_ONE;
            eff_color    = color_reg;
            eff_active   = 1'b1;
        end
        else
        begin
            eff_x        = cursor_x_reg;
            eff_y        = cursor_y_reg;
            eff_decision = decision_reg;
            eff_major    = major_reg;
            eff_minor    = minor_reg;
            eff_dir      = dir_reg;
            eff_left     = left_reg;
            eff_color    = held_color_reg;
            eff_active   = active_reg;
        end
    end

    lpg_step #(
        .COORD_BITS (CB)
    ) u_step (
        .cursor_x      (eff_x),
        .cursor_y      (eff_y),
        .decision      (eff_decision),
        .delta_major   (eff_major),
        .delta_minor   (eff_minor),
        .dir           (eff_dir),
        .step_x        (step_x),
        .step_y        (step_y),
        .step_decision (step_decision)
    );

    assign left_dec = eff_left - LEFT_ONE;

    // pixel result and next line state
    always_comb
    begin
        cursor_x_next    = eff_x;
        cursor_y_next    = eff_y;
        decision_next    = eff_decision;
        major_next       = eff_major;
        minor_next       = eff_minor;
        dir_next         = eff_dir;
        left_next        = eff_left;
        held_color_next  = eff_color;
        active_next      = eff_active;
        pixel_valid_next = 1'b0;
        pixel_x_next     = '0;
        pixel_y_next     = '0;
        pixel_color_next = '0;
        last_pixel_next  = 1'b0;
        if (eff_active)
        begin
            pixel_valid_next = 1'b1;
            pixel_x_next     = eff_x;
            pixel_y_next     = eff_y;
            pixel_color_next = eff_color;
            last_pixel_next  = (eff_left == LEFT_ONE);
            left_next        = left_dec;
            if (left_dec == '0)
            begin
                active_next = 1'b0;
            end
            else
            begin
                cursor_x_next = step_x;
                cursor_y_next = step_y;
                decision_next = step_decision;
            end
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            action_reg  <= lpg_action_t'(action);
            start_x_reg <= start_x;
            start_y_reg <= start_y;
            end_x_reg   <= end_x;
            end_y_reg   <= end_y;
            color_reg   <= line_color;
        end
    end

    // line state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg   <= '0;
            cursor_y_reg   <= '0;
            decision_reg   <= '0;
            major_reg      <= '0;
            minor_reg      <= '0;
            dir_reg        <= '0;
            left_reg       <= '0;
            held_color_reg <= '0;
            active_reg     <= 1'b0;
        end
        else if (fire)
        begin
            cursor_x_reg   <= cursor_x_next;
            cursor_y_reg   <= cursor_y_next;
            decision_reg   <= decision_next;
            major_reg      <= major_next;
            minor_reg      <= minor_next;
            dir_reg        <= dir_next;
            left_reg       <= left_next;
            held_color_reg <= held_color_next;
            active_reg     <= active_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            pixel_valid_reg <= pixel_valid_next;
            pixel_x_reg     <= pixel_x_next;
            pixel_y_reg     <= pixel_y_next;
            pixel_color_reg <= pixel_color_next;
            last_pixel_reg  <= last_pixel_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_valid = pixel_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign pixel_color = pixel_color_reg;
    assign last_pixel  = last_pixel_reg;

endmodule

[hw/rtl/lpg_setup.sv]
`timescale 1ns / 1ps
// lpg_setup: line setup from two endpoints (deltas, major axis, directions, first term)
// depends on lpg_pkg
module lpg_setup #(
    parameter int unsigned COORD_BITS = 10
) (
    input  logic [COORD_BITS-1:0]        start_x,
    input  logic [COORD_BITS-1:0]        start_y,
    input  logic [COORD_BITS-1:0]        end_x,
    input  logic [COORD_BITS-1:0]        end_y,
    output logic [COORD_BITS-1:0]        delta_major,
    output logic [COORD_BITS-1:0]        delta_minor,
    output lpg_pkg::lpg_dir_t            dir,
    output logic signed [COORD_BITS+2:0] decision_init
);
    import lpg_pkg::*;

    logic [COORD_BITS-1:0]        dx;
    logic [COORD_BITS-1:0]        dy;
    logic signed [COORD_BITS+2:0] twice_minor;
    logic signed [COORD_BITS+2:0] major_ext;

    // absolute deltas and step directions
    always_comb
    begin
        dir.step_x_negative = start_x > end_x;
        dir.step_y_negative = start_y > end_y;
        dx = dir.step_x_negative ? (start_x - end_x) : (end_x - start_x);
        dy = dir.step_y_negative ? (start_y - end_y) : (end_y - start_y);
        // ties go to x
        dir.x_is_major = dx >= dy;
        delta_major = dir.x_is_major ? dx : dy;
        delta_minor = dir.x_is_major ? dy : dx;
    end

    // first decision term: 2*minor - major
    assign twice_minor   = $signed({2'b00, delta_minor, 1'b0});
    assign major_ext     = $signed({3'b000, delta_major});
    assign decision_init = twice_minor - major_ext;

endmodule

[hw/rtl/lpg_step.sv]
`timescale 1ns / 1ps
// lpg_step: one bresenham step of the cursor and decision term
// depends on lpg_pkg
module lpg_step #(
    parameter int unsigned COORD_BITS = 10
) (
    input  logic [COORD_BITS-1:0]        cursor_x,
    input  logic [COORD_BITS-1:0]        cursor_y,
    input  logic signed [COORD_BITS+2:0] decision,
    input  logic [COORD_BITS-1:0]        delta_major,
    input  logic [COORD_BITS-1:0]        delta_minor,
    input  lpg_pkg::lpg_dir_t            dir,
    output logic [COORD_BITS-1:0]        step_x,
    output logic [COORD_BITS-1:0]        step_y,
    output logic signed [COORD_BITS+2:0] step_decision
);
    import lpg_pkg::*;

    localparam logic [COORD_BITS-1:0] ONE = COORD_BITS'(1);

    logic                         both;
    logic signed [COORD_BITS+2:0] twice_minor;
    logic signed [COORD_BITS+2:0] twice_major;
    logic [COORD_BITS-1:0]        moved_x;
    logic [COORD_BITS-1:0]        moved_y;

    assign twice_minor = $signed({2'b00, delta_minor, 1'b0});
    assign twice_major = $signed({2'b00, delta_major, 1'b0});

    // non-negative term steps both axes
    assign both = ~decision[COORD_BITS+2];

    // decision update
    assign step_decision = both ? (decision + twice_minor - twice_major)
                                : (decision + twice_minor);

    // cursor moves, wrapping at the coordinate width
    assign moved_x = dir.step_x_negative ? (cursor_x - ONE) : (cursor_x + ONE);
    assign moved_y = dir.step_y_negative ? (cursor_y - ONE) : (cursor_y + ONE);
    assign step_x  = (dir.x_is_major || both) ? moved_x : cursor_x;
    assign step_y  = (!dir.x_is_major || both) ? moved_y : cursor_y;

endmodule

[hw/rtl/lpg_checker.sv]
`timescale 1ns / 1ps
// lpg_checker: port-level checks of the line pixel generator, bound to the top level
// depends on lpg_pkg and line_pixel_generator_core
module lpg_checker #(
    parameter int unsigned COORD_BITS = 10
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic                           pixel_valid,
    input logic [COORD_BITS-1:0]          pixel_x,
    input logic [COORD_BITS-1:0]          pixel_y,
    input logic [lpg_pkg::COLOR_BITS-1:0] pixel_color,
    input logic                           last_pixel
);
    import lpg_pkg::*;

    // a stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
            && $stable(pixel_color) && $stable(pixel_valid) && $stable(last_pixel))
        else $error("result item changed while stalled");

    // an empty result slot never blocks the input
    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty result register");

    // advance with no line gives an all-zero result
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !pixel_valid |-> pixel_x == '0 && pixel_y == '0
            && pixel_color == '0 && !last_pixel)
        else $error("non-pixel result carries data");

    // last flag only on a real pixel
    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_pixel |-> pixel_valid)
        else $error("last flag without a pixel");

endmodule

bind line_pixel_generator_core lpg_checker #(.COORD_BITS(COORD_BITS)) u_lpg_checker (.*);
